@@ rtl/gregorian_date_difference_defines.svh @@
// Assertion macros for the Gregorian date difference block.
// Included by files that carry concurrent assertions; expects clk and rst in scope.
`ifndef GREGORIAN_DATE_DIFFERENCE_DEFINES_SVH
`define GREGORIAN_DATE_DIFFERENCE_DEFINES_SVH
`ifndef SYNTHESIS
`define GDD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GDD_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GDD_ASSERT(name, prop, msg)
`define GDD_ASSERT_RST(name, prop, msg)
`endif
`endif

@@ rtl/gdd_pkg.sv @@
// Package for the Gregorian date difference block: widths, microcode types,
// the control store and calendar tables. No dependencies.
package gdd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 22;
  localparam int SER_W   = 23;
  localparam int PC_W    = 4;
  localparam int C100_W  = 8;
  localparam int C400_W  = 6;
  localparam int LEAPS_W = 13;
  localparam int CUM_W   = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int RECIP_SHIFT = 19;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_DIV,
    OP_LEAP,
    OP_BASE,
    OP_CHECK,
    OP_DIFF
  } op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_ERR,
    JMP_END
  } jmp_t;

  typedef struct packed {
    op_t             op;
    logic            sel;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic sel;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic hold;
    logic err;
  } status_t;

  localparam logic [PC_W-1:0] PC_DIFF = 4'd8;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, sel: 1'b0, jmp: JMP_END, target: '0};
    case (pc)
      4'd0: w = '{op: OP_DIV,   sel: 1'b0, jmp: JMP_NEXT, target: '0};
      4'd1: w = '{op: OP_LEAP,  sel: 1'b0, jmp: JMP_NEXT, target: '0};
      4'd2: w = '{op: OP_BASE,  sel: 1'b0, jmp: JMP_NEXT, target: '0};
      4'd3: w = '{op: OP_CHECK, sel: 1'b0, jmp: JMP_ERR,  target: PC_DIFF};
      4'd4: w = '{op: OP_DIV,   sel: 1'b1, jmp: JMP_NEXT, target: '0};
      4'd5: w = '{op: OP_LEAP,  sel: 1'b1, jmp: JMP_NEXT, target: '0};
      4'd6: w = '{op: OP_BASE,  sel: 1'b1, jmp: JMP_NEXT, target: '0};
      4'd7: w = '{op: OP_CHECK, sel: 1'b1, jmp: JMP_NEXT, target: '0};
      4'd8: w = '{op: OP_DIFF,  sel: 1'b0, jmp: JMP_END,  target: '0};
      default: w = '{op: OP_NOP, sel: 1'b0, jmp: JMP_END, target: '0};
    endcase
    return w;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] m,
                                                input logic leap);
    logic [CUM_W-1:0] c;
    case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    if (leap && m > 4'd2 && m <= 4'd12) begin
      c = c + 9'd1;
    end
    return c;
  endfunction

endpackage

@@ rtl/gdd_if.sv @@
// Request and response channel interfaces for the date difference block.
// Depends on gdd_pkg for field widths.
interface gdd_req_if;
  logic                           valid;
  logic                           ready;
  logic [gdd_pkg::YEAR_W-1:0]     start_year;
  logic [gdd_pkg::MONTH_W-1:0]    start_month;
  logic [gdd_pkg::DAY_W-1:0]      start_day;
  logic [gdd_pkg::YEAR_W-1:0]     end_year;
  logic [gdd_pkg::MONTH_W-1:0]    end_month;
  logic [gdd_pkg::DAY_W-1:0]      end_day;
  logic                           include_end;

  modport source (output valid, start_year, start_month, start_day, end_year, end_month,
                  end_day, include_end, input ready);
  modport sink (input valid, start_year, start_month, start_day, end_year, end_month,
                end_day, include_end, output ready);
endinterface

interface gdd_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [gdd_pkg::COUNT_W-1:0] day_count;
  logic                        date_error;

  modport source (output valid, day_count, date_error, input ready);
  modport sink (input valid, day_count, date_error, output ready);
endinterface

@@ rtl/gdd_seq.sv @@
// Microcode sequencer: step counter, control store lookup and jumps.
// Depends on gdd_pkg for the control store and control types.
module gdd_seq (
  input  logic             clk,
  input  logic             rst,
  input  gdd_pkg::status_t status,
  output gdd_pkg::ctrl_t   ctrl,
  output logic             busy
);

  logic [gdd_pkg::PC_W-1:0] pc;
  logic [gdd_pkg::PC_W-1:0] pc_next;
  logic                     busy_next;
  gdd_pkg::uword_t          uw;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      busy <= 1'b0;
    end else begin
      pc   <= pc_next;
      busy <= busy_next;
    end
  end

  always_comb begin
    uw        = gdd_pkg::ucode(pc);
    pc_next   = pc;
    busy_next = busy;
    ctrl.op   = busy ? uw.op : gdd_pkg::OP_NOP;
    ctrl.sel  = uw.sel;
    if (!busy) begin
      if (status.start) begin
        busy_next = 1'b1;
        pc_next   = '0;
      end
    end else if (!status.hold) begin
      case (uw.jmp)
        gdd_pkg::JMP_NEXT: pc_next = pc + gdd_pkg::PC_W'(1);
        gdd_pkg::JMP_ERR:  pc_next = status.err ? uw.target : pc + gdd_pkg::PC_W'(1);
        gdd_pkg::JMP_END: begin
          pc_next   = '0;
          busy_next = 1'b0;
        end
        default: begin
          pc_next   = '0;
          busy_next = 1'b0;
        end
      endcase
    end
  end

endmodule

@@ rtl/gregorian_date_difference.sv @@
// Gregorian date difference: days from a start date to an end date, plus one
// when include_end is set; zero with date_error when either date is invalid.
// Each item runs the microcode from acceptance into the output register,
// skipping the end date if the start date is already invalid: a reciprocal
// multiply by 1/100, leap-year logic, a 365*year base and a month/day check
// for each date, then the subtract and clamp; one step per cycle, but the
// final step holds only while a previous result has not been taken. A new
// item is accepted once the program ends, even while the last result waits.
// Depends on gdd_pkg, gdd_if, gdd_seq and the assertion macro header.
`include "gregorian_date_difference_defines.svh"

module gregorian_date_difference (
  input  logic        clk,
  input  logic        rst,
  gdd_req_if.sink     req,
  gdd_rsp_if.source   rsp
);

  logic [gdd_pkg::YEAR_W-1:0]  sy, ey;
  logic [gdd_pkg::MONTH_W-1:0] sm, em;
  logic [gdd_pkg::DAY_W-1:0]   sd, ed;
  logic                        inc;

  logic [gdd_pkg::C100_W-1:0]  c100;
  logic                        leap;
  logic [gdd_pkg::LEAPS_W-1:0] leaps;
  logic [gdd_pkg::SER_W-1:0]   ser_a, ser_b;
  logic                        err;

  logic                        out_valid;
  logic [gdd_pkg::COUNT_W-1:0] count;
  logic                        count_err;

  gdd_pkg::ctrl_t              ctrl;
  gdd_pkg::status_t            status;
  logic                        busy;

  logic [gdd_pkg::YEAR_W-1:0]  yr;
  logic [gdd_pkg::MONTH_W-1:0] mo;
  logic [gdd_pkg::DAY_W-1:0]   dy;
  logic [gdd_pkg::SER_W-1:0]   ser_sel;
  logic [14:0]                 yr_w;
  logic [27:0]                 prod;
  logic [8:0]                  c100_p3;
  logic [gdd_pkg::C400_W-1:0]  c400;
  logic [14:0]                 yp3;
  logic                        m100, m400, leap_new;
  logic [gdd_pkg::LEAPS_W-1:0] leaps_new;
  logic [gdd_pkg::SER_W-1:0]   base;
  logic [gdd_pkg::DAY_W-1:0]   mlen;
  logic                        bad;
  logic [gdd_pkg::SER_W-1:0]   checked;
  logic [gdd_pkg::SER_W-1:0]   diff;
  logic [gdd_pkg::SER_W:0]     diff_inc;
  logic [gdd_pkg::COUNT_W-1:0] count_new;
  logic                        accept;
  logic                        is_diff;
  logic                        commit;

  assign accept  = req.valid && req.ready;
  assign req.ready = !busy && !rst;
  assign is_diff = (ctrl.op == gdd_pkg::OP_DIFF);
  assign commit  = is_diff && (!out_valid || rsp.ready);

  assign status.start = accept;
  assign status.hold  = is_diff && out_valid && !rsp.ready;
  assign status.err   = err || ((ctrl.op == gdd_pkg::OP_CHECK) && bad);

  gdd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  always_comb begin
    yr      = ctrl.sel ? ey : sy;
    mo      = ctrl.sel ? em : sm;
    dy      = ctrl.sel ? ed : sd;
    ser_sel = ctrl.sel ? ser_b : ser_a;
    yr_w    = {1'b0, yr};

    prod    = 28'(yr_w + 15'd99) * 28'(gdd_pkg::RECIP_100);

    c100_p3 = {1'b0, c100} + 9'd3;
    c400    = c100_p3[7:2];
    m100    = (15'(c100) * 15'd100) == yr_w;
    m400    = (15'(c400) * 15'd400) == yr_w;
    leap_new = ((yr[1:0] == 2'b00) && !m100) || m400;
    yp3     = yr_w + 15'd3;
    leaps_new = yp3[14:2] - gdd_pkg::LEAPS_W'(c100) + gdd_pkg::LEAPS_W'(c400);

    base    = gdd_pkg::SER_W'(yr) * 23'd365 + gdd_pkg::SER_W'(leaps);

    mlen    = gdd_pkg::month_len(mo, leap);
    bad     = (mlen == '0) || (dy == '0) || (dy > mlen);
    checked = ser_sel + gdd_pkg::SER_W'(gdd_pkg::cum_days(mo, leap))
              + gdd_pkg::SER_W'(dy);

    diff     = (ser_b > ser_a) ? ser_b - ser_a : '0;
    diff_inc = {1'b0, diff} + (gdd_pkg::SER_W + 1)'(inc);
    if (err) begin
      count_new = '0;
    end else if (diff_inc > (gdd_pkg::SER_W + 1)'(gdd_pkg::COUNT_MAX)) begin
      count_new = gdd_pkg::COUNT_MAX;
    end else begin
      count_new = diff_inc[gdd_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sy  <= req.start_year;
      sm  <= req.start_month;
      sd  <= req.start_day;
      ey  <= req.end_year;
      em  <= req.end_month;
      ed  <= req.end_day;
      inc <= req.include_end;
    end
    case (ctrl.op)
      gdd_pkg::OP_DIV:  c100 <= prod[gdd_pkg::RECIP_SHIFT +: gdd_pkg::C100_W];
      gdd_pkg::OP_LEAP: begin
        leap  <= leap_new;
        leaps <= leaps_new;
      end
      gdd_pkg::OP_BASE: begin
        if (ctrl.sel) begin
          ser_b <= base;
        end else begin
          ser_a <= base;
        end
      end
      gdd_pkg::OP_CHECK: begin
        if (ctrl.sel) begin
          ser_b <= checked;
        end else begin
          ser_a <= checked;
        end
      end
      default: begin
      end
    endcase
    if (commit) begin
      count     <= count_new;
      count_err <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        err <= 1'b0;
      end else begin
        err <= status.err;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.day_count  = count;
  assign rsp.date_error = count_err;

  `GDD_ASSERT(a_err_count_zero, rsp.valid && rsp.date_error |-> rsp.day_count == '0, "count not zero")
  `GDD_ASSERT(a_accept_starts, req.valid && req.ready |=> busy, "item did not start")
  `GDD_ASSERT(a_busy_has_op, busy |-> ctrl.op != gdd_pkg::OP_NOP, "sequencer busy on empty step")
  `GDD_ASSERT_RST(a_reset_idle, rst |=> !rsp.valid && !busy, "block not idle after reset")

endmodule

@@ tb/tb_gregorian_date_difference.sv @@
`timescale 1ns / 100ps
// Testbench for gregorian_date_difference: drives date pairs, predicts day counts and
// date errors in its own calendar arithmetic, and checks every result in order.
// Depends on gdd_pkg, the gdd_req_if/gdd_rsp_if interfaces and the block itself.

module tb_gregorian_date_difference;
  import gdd_pkg::*;

  localparam int TOTAL_ITEMS  = 1150;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 24;
  localparam int MAX_REPORTS  = 10;
  localparam int PREDICT      = -1;
  localparam int YEAR_TOP     = 2**YEAR_W - 1;

  typedef struct packed {
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;
    logic               include_end;
  } date_pair_t;

  typedef struct packed {
    logic [COUNT_W-1:0] day_count;
    logic               date_error;
  } diff_result_t;

  typedef struct {
    date_pair_t pair;
    int         fixed_count;
    bit         fixed_error;
  } directed_row_t;

  logic clk;
  logic rst;

  gdd_req_if req_ch ();
  gdd_rsp_if rsp_ch ();

  gregorian_date_difference dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  diff_result_t  pending_results[$];
  directed_row_t directed_rows[$];
  diff_result_t  want;
  int items_sent;
  int n_directed;
  int results_seen = 0;
  int faults       = 0;
  int stall_cycles = 0;
  int burst_left;
  int n_invalid    = 0;
  int n_saturated  = 0;
  int unsigned special_years [14] = '{0, 1, 4, 100, 400, 1600, 1700, 1900, 2000, 2100,
                                      2400, 9999, 16000, 16383};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic bit date_ok(int unsigned y, int unsigned m, int unsigned d);
    int unsigned len;
    len = month_days(y, m);
    return (len != 0) && (d >= 1) && (d <= len);
  endfunction

  // count days from January 1 of year zero
  function automatic int unsigned day_number(int unsigned y, int unsigned m, int unsigned d);
    int unsigned n;
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int unsigned k = 1; k < m; k++) begin
      n += month_days(y, k);
    end
    return n + d;
  endfunction

  function automatic diff_result_t predict_difference(date_pair_t p);
    diff_result_t res;
    int unsigned  a;
    int unsigned  b;
    int unsigned  span;
    res = '0;
    if (!date_ok(p.start_year, p.start_month, p.start_day) ||
        !date_ok(p.end_year, p.end_month, p.end_day)) begin
      res.date_error = 1'b1;
    end else begin
      a = day_number(p.start_year, p.start_month, p.start_day);
      b = day_number(p.end_year, p.end_month, p.end_day);
      span = (a < b) ? b - a : 0;
      span += p.include_end;
      if (span > COUNT_MAX) begin
        span = 32'(COUNT_MAX);
      end
      res.day_count = span[COUNT_W-1:0];
    end
    return res;
  endfunction

  function automatic void add_row(int sy, int sm, int sd, int ey, int em, int ed, int inc,
                                  int fixed_count, bit fixed_error);
    directed_row_t row;
    row.pair = '{start_year: YEAR_W'(sy), start_month: MONTH_W'(sm),
                 start_day: DAY_W'(sd), end_year: YEAR_W'(ey),
                 end_month: MONTH_W'(em), end_day: DAY_W'(ed), include_end: 1'(inc)};
    row.fixed_count = fixed_count;
    row.fixed_error = fixed_error;
    directed_rows.push_back(row);
  endfunction

  function automatic int unsigned pick_year();
    case ($urandom_range(7))
      0, 1, 2: return $urandom_range(1, 9999);
      3:       return $urandom_range(0, YEAR_TOP);
      4:       return special_years[$urandom_range(13)];
      5:       return $urandom_range(1890, 2110);
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  function automatic int unsigned pick_day(int unsigned y, int unsigned m);
    int unsigned len;
    len = month_days(y, m);
    case ($urandom_range(3))
      0:       return 1;
      1:       return len;
      default: return $urandom_range(1, len);
    endcase
  endfunction

  function automatic date_pair_t random_pair();
    date_pair_t  p;
    int unsigned y [2];
    int unsigned m [2];
    int unsigned d [2];
    int unsigned kind;
    int unsigned idx;
    int unsigned len;
    kind = $urandom_range(99);
    y[0] = pick_year();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: y[1] = y[0] + $urandom_range(3);
      5, 6, 7:       y[1] = pick_year();
      default:       y[1] = y[0];
    endcase
    if (y[1] > YEAR_TOP) begin
      y[1] = y[0];
    end
    for (int i = 0; i < 2; i++) begin
      m[i] = $urandom_range(1, 12);
      d[i] = pick_day(y[i], m[i]);
    end
    if ($urandom_range(9) == 0) begin
      y = '{y[1], y[0]};
      m = '{m[1], m[0]};
      d = '{d[1], d[0]};
    end
    if (kind < 8) begin
      y[1] = y[0];
      m[1] = m[0];
      d[1] = d[0];
    end else if (kind < 24) begin
      idx = $urandom_range(1);
      len = month_days(y[idx], m[idx]);
      if ($urandom_range(1)) begin
        m[idx] = $urandom_range(12, 15);
        if (m[idx] == 12) begin
          m[idx] = 0;
        end
      end else if (len == 31 || $urandom_range(1)) begin
        d[idx] = 0;
      end else begin
        d[idx] = $urandom_range(len + 1, 31);
      end
    end else if (kind < 33) begin
      for (int i = 0; i < 2; i++) begin
        y[i] = $urandom_range(0, YEAR_TOP);
        m[i] = $urandom_range(0, 15);
        d[i] = $urandom_range(0, 31);
      end
    end
    p.start_year  = YEAR_W'(y[0]);
    p.start_month = MONTH_W'(m[0]);
    p.start_day   = DAY_W'(d[0]);
    p.end_year    = YEAR_W'(y[1]);
    p.end_month   = MONTH_W'(m[1]);
    p.end_day     = DAY_W'(d[1]);
    p.include_end = 1'($urandom_range(1));
    return p;
  endfunction

  task automatic send_pair(input date_pair_t p, input diff_result_t expected);
    int gap;
    @(negedge clk);
    req_ch.valid       <= 1'b1;
    req_ch.start_year  <= p.start_year;
    req_ch.start_month <= p.start_month;
    req_ch.start_day   <= p.start_day;
    req_ch.end_year    <= p.end_year;
    req_ch.end_month   <= p.end_month;
    req_ch.end_day     <= p.end_day;
    req_ch.include_end <= p.include_end;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(expected);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic report_fault(input string what, input logic [31:0] expected,
                              input logic [31:0] actual);
    faults++;
    if (faults <= MAX_REPORTS) begin
      $display("result %0d: %s expected %0d, got %0d", results_seen, what, expected, actual);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        faults++;
        if (faults <= MAX_REPORTS) begin
          $display("result %0d arrived with nothing outstanding", results_seen);
        end
      end else begin
        want = pending_results.pop_front();
        if (want.date_error) begin
          n_invalid++;
        end else if (want.day_count == COUNT_MAX) begin
          n_saturated++;
        end
        if (rsp_ch.day_count !== want.day_count) begin
          report_fault("day_count", 32'(want.day_count), 32'(rsp_ch.day_count));
        end
        if (rsp_ch.date_error !== want.date_error) begin
          report_fault("date_error", 32'(want.date_error), 32'(rsp_ch.date_error));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no item moved for %0d cycles, %0d results outstanding", STALL_LIMIT,
                 pending_results.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : receiver
    int stall_pct;
    int phase_len;
    bit held;
    rsp_ch.ready = 1'b0;
    held = 1'b0;
    wait (rst === 1'b0);
    forever begin
      phase_len = $urandom_range(10, 200);
      case ($urandom_range(3))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        2:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      repeat (phase_len) begin
        @(negedge clk);
        // hold off long enough for the block to back up into its input
        if (!held && items_sent >= HOLD_AFTER) begin
          held = 1'b1;
          rsp_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : stimulus
    directed_row_t row;
    diff_result_t  fixed;
    date_pair_t    pair;
    rst = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.start_year  = '0;
    req_ch.start_month = '0;
    req_ch.start_day   = '0;
    req_ch.end_year    = '0;
    req_ch.end_month   = '0;
    req_ch.end_day     = '0;
    req_ch.include_end = 1'b0;
    items_sent   = 0;
    burst_left   = 0;

    add_row(2000, 1, 1, 2000, 1, 1, 0, 0, 0);
    add_row(2000, 1, 1, 2000, 1, 1, 1, 1, 0);
    add_row(2000, 1, 1, 2000, 1, 2, 0, 1, 0);
    add_row(2000, 0, 1, 2000, 1, 2, 1, 0, 1);
    add_row(2000, 1, 1, 2000, 13, 2, 1, 0, 1);
    add_row(2000, 15, 31, 2000, 1, 2, 0, 0, 1);
    add_row(2000, 5, 0, 2001, 1, 2, 1, 0, 1);
    add_row(1999, 3, 1, 2000, 4, 31, 0, 0, 1);
    add_row(1900, 2, 29, 1901, 1, 1, 1, 0, 1);
    add_row(2000, 2, 30, 2000, 3, 1, 0, 0, 1);
    add_row(2000, 2, 29, 2000, 3, 1, 0, 1, 0);
    add_row(2024, 2, 29, 2024, 3, 1, 0, 1, 0);
    add_row(2100, 2, 28, 2100, 3, 1, 0, 1, 0);
    add_row(1900, 2, 28, 1900, 3, 1, 0, 1, 0);
    add_row(1999, 12, 31, 2000, 1, 1, 0, 1, 0);
    add_row(0, 1, 1, 0, 12, 31, 1, 366, 0);
    add_row(0, 2, 29, 0, 3, 1, 0, 1, 0);
    add_row(9999, 12, 31, 1, 1, 1, 1, 1, 0);
    add_row(1, 1, 1, 9999, 12, 31, 1, 3652059, 0);
    add_row(0, 1, 1, 16383, 12, 31, 1, COUNT_MAX, 0);
    add_row(16383, 15, 31, 16383, 15, 31, 1, 0, 1);
    add_row(16383, 12, 31, 16383, 12, 31, 0, 0, 0);
    add_row(2023, 1, 15, 2023, 11, 20, 0, PREDICT, 0);
    add_row(2400, 2, 29, 2401, 2, 28, 0, PREDICT, 0);
    add_row(1, 1, 1, 16383, 1, 1, 0, PREDICT, 0);

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.fixed_count == PREDICT) begin
        send_pair(row.pair, predict_difference(row.pair));
      end else begin
        fixed.day_count  = COUNT_W'(row.fixed_count);
        fixed.date_error = row.fixed_error;
        send_pair(row.pair, fixed);
      end
    end
    n_directed = items_sent;

    while (items_sent < TOTAL_ITEMS) begin
      pair = random_pair();
      send_pair(pair, predict_difference(pair));
    end
    @(negedge clk);
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d date pairs sent (%0d directed), %0d results checked, %0d mismatches",
             items_sent, n_directed, results_seen, faults);
    $display("%0d results flagged an invalid date, %0d counts saturated",
             n_invalid, n_saturated);
    if (faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
